@@ hw/rtl/rsp_pkg.sv @@
// shared types, codes and constants for the request stream parser
package rsp_pkg;

  localparam int unsigned NUMBER_CHARS_DEF = 16;
  localparam int unsigned LENGTH_BITS_DEF  = 28;
  localparam int unsigned COUNT_BITS_DEF   = 10;

  localparam int unsigned COUNT_CFG_W  = 10;
  localparam int unsigned LENGTH_CFG_W = 28;
  localparam int unsigned INDEX_W      = 10;

  localparam logic [COUNT_CFG_W-1:0]  MAX_COUNT_RESET  = 10'd128;
  localparam logic [LENGTH_CFG_W-1:0] MAX_LENGTH_RESET = 28'h0FFFFFFF;

  localparam logic CFG_IDX_COUNT  = 1'b0;
  localparam logic CFG_IDX_LENGTH = 1'b1;

  localparam logic [7:0] CHAR_CR     = 8'h0D;
  localparam logic [7:0] CHAR_LF     = 8'h0A;
  localparam logic [7:0] CHAR_MINUS  = 8'h2D;
  localparam logic [7:0] CHAR_PLUS   = 8'h2B;
  localparam logic [7:0] CHAR_STAR   = 8'h2A;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_NINE   = 8'h39;

  typedef enum logic [1:0] {
    ST_PENDING    = 2'd0,
    ST_OK         = 2'd1,
    ST_ERROR      = 2'd2,
    ST_INCOMPLETE = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]         data_byte;
    logic               data_valid;
    logic [INDEX_W-1:0] param_index;
    logic               param_end;
    status_e            status;
  } res_t;

endpackage

@@ hw/rtl/resp_request_stream_parser_top.sv @@
// top level of the request stream parser
//
//  channel  direction  handshake                  payload
//  in       sink       in_valid_i / in_stall_o    byte_value_i, buffer_end_i
//  out      source     out_valid_o / out_stall_i  data_byte_o, data_valid_o,
//                                                 param_index_o, param_end_o, status_o
//  cfg      sink       cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// one byte per cycle unless the output stalls; bytes pass input, then result register
// the rate is set by the combinational parse step between input and result register
// rst_ni clears all control state, limits return to 128 and 0x0FFFFFFF
// a stalled output holds its result; the input register then fills and stalls the input
// cfg_ready_o is always high
module resp_request_stream_parser_top #(
  parameter int unsigned NUMBER_CHARS = rsp_pkg::NUMBER_CHARS_DEF,
  parameter int unsigned LENGTH_BITS  = rsp_pkg::LENGTH_BITS_DEF,
  parameter int unsigned COUNT_BITS   = rsp_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [7:0]                       byte_value_i,
  input  logic                             buffer_end_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [7:0]                       data_byte_o,
  output logic                             data_valid_o,
  output logic [rsp_pkg::INDEX_W-1:0]      param_index_o,
  output logic                             param_end_o,
  output logic [1:0]                       status_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic                             cfg_index_i,
  input  logic [rsp_pkg::LENGTH_CFG_W-1:0] cfg_data_i
);

  logic                             in_valid_q, in_valid_d;
  logic [7:0]                       byte_q;
  logic                             end_q;
  logic                             accept, advance, out_free;
  logic [rsp_pkg::COUNT_CFG_W-1:0]  max_count;
  logic [rsp_pkg::LENGTH_CFG_W-1:0] max_length;
  rsp_pkg::res_t                    step_res, out_res;

  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= byte_value_i;
      end_q  <= buffer_end_i;
    end
  end

  rsp_cfg_regs u_cfg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .max_count_o  (max_count),
    .max_length_o (max_length)
  );

  rsp_parser #(
    .NUMBER_CHARS (NUMBER_CHARS),
    .LENGTH_BITS  (LENGTH_BITS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .byte_i       (byte_q),
    .end_i        (end_q),
    .max_count_i  (max_count),
    .max_length_i (max_length),
    .res_o        (step_res)
  );

  rsp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (advance),
    .res_i       (step_res),
    .out_stall_i (out_stall_i),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .res_o       (out_res)
  );

  assign data_byte_o   = out_res.data_byte;
  assign data_valid_o  = out_res.data_valid;
  assign param_index_o = out_res.param_index;
  assign param_end_o   = out_res.param_end;
  assign status_o      = out_res.status;

endmodule

@@ hw/rtl/rsp_cfg_regs.sv @@
// configuration registers for count and length limits
module rsp_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic                                cfg_index_i,
  input  logic [rsp_pkg::LENGTH_CFG_W-1:0]    cfg_data_i,
  output logic [rsp_pkg::COUNT_CFG_W-1:0]     max_count_o,
  output logic [rsp_pkg::LENGTH_CFG_W-1:0]    max_length_o
);

  logic [rsp_pkg::COUNT_CFG_W-1:0]  max_count_q, max_count_d;
  logic [rsp_pkg::LENGTH_CFG_W-1:0] max_length_q, max_length_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    max_count_d  = max_count_q;
    max_length_d = max_length_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        rsp_pkg::CFG_IDX_COUNT:  max_count_d  = cfg_data_i[rsp_pkg::COUNT_CFG_W-1:0];
        rsp_pkg::CFG_IDX_LENGTH: max_length_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_count_q  <= rsp_pkg::MAX_COUNT_RESET;
      max_length_q <= rsp_pkg::MAX_LENGTH_RESET;
    end else begin
      max_count_q  <= max_count_d;
      max_length_q <= max_length_d;
    end
  end

  assign max_count_o  = max_count_q;
  assign max_length_o = max_length_q;

endmodule

@@ hw/rtl/rsp_parser.sv @@
// parse state machine, number accumulator and per-byte result logic
module rsp_parser #(
  parameter int unsigned NUMBER_CHARS = rsp_pkg::NUMBER_CHARS_DEF,
  parameter int unsigned LENGTH_BITS  = rsp_pkg::LENGTH_BITS_DEF,
  parameter int unsigned COUNT_BITS   = rsp_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             step_i,
  input  logic [7:0]                       byte_i,
  input  logic                             end_i,
  input  logic [rsp_pkg::COUNT_CFG_W-1:0]  max_count_i,
  input  logic [rsp_pkg::LENGTH_CFG_W-1:0] max_length_i,
  output rsp_pkg::res_t                    res_o
);

  localparam int unsigned NUM_BITS = (LENGTH_BITS > COUNT_BITS ? LENGTH_BITS : COUNT_BITS) + 1;
  localparam int unsigned CMP_W    = NUM_BITS > rsp_pkg::LENGTH_CFG_W ?
                                     NUM_BITS : rsp_pkg::LENGTH_CFG_W;
  localparam int unsigned DC_W     = $clog2(NUMBER_CHARS + 1);

  localparam logic [3:0] PH_STAR    = 4'd0;
  localparam logic [3:0] PH_CNUM    = 4'd1;
  localparam logic [3:0] PH_CLF     = 4'd2;
  localparam logic [3:0] PH_DOLLAR  = 4'd3;
  localparam logic [3:0] PH_LNUM    = 4'd4;
  localparam logic [3:0] PH_LLF     = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_DCR     = 4'd7;
  localparam logic [3:0] PH_DLF     = 4'd8;

  localparam logic [CMP_W-1:0] CNT_LIMIT = CMP_W'({COUNT_BITS{1'b1}});
  localparam logic [CMP_W-1:0] LEN_LIMIT = CMP_W'({LENGTH_BITS{1'b1}});

  logic [3:0]             phase_q, phase_d;
  logic [NUM_BITS-1:0]    num_q, num_d;
  logic                   neg_q, neg_d;
  logic                   stop_q, stop_d;
  logic [DC_W-1:0]        dc_q, dc_d;
  logic [COUNT_BITS-1:0]  params_q, params_d;
  logic [COUNT_BITS-1:0]  index_q, index_d;
  logic [LENGTH_BITS-1:0] payload_q, payload_d;
  rsp_pkg::status_e       decided_q, decided_d;

  logic                   is_digit, is_num, take;
  logic [NUM_BITS+3:0]    mul10;
  logic [NUM_BITS-1:0]    num_acc;
  logic [NUM_BITS-1:0]    num_t;
  logic                   neg_t, stop_t;
  logic [NUM_BITS-1:0]    chk_num;
  logic                   chk_neg;
  logic [CMP_W-1:0]       chk_ext, cnt_lim, len_lim;
  logic                   count_bad, length_bad, bad;
  logic [LENGTH_BITS-1:0] payload_dec;
  logic [COUNT_BITS-1:0]  params_dec;
  rsp_pkg::status_e       st;
  rsp_pkg::res_t          res;

  // number accumulator
  assign is_digit = byte_i inside {[rsp_pkg::CHAR_ZERO:rsp_pkg::CHAR_NINE]};
  assign is_num   = is_digit || byte_i == rsp_pkg::CHAR_MINUS || byte_i == rsp_pkg::CHAR_PLUS;
  assign take     = is_num && (dc_q < DC_W'(NUMBER_CHARS));
  assign mul10    = {3'b000, num_q, 1'b0} + {1'b0, num_q, 3'b000}
                  + (NUM_BITS+4)'(byte_i[3:0]);
  assign num_acc  = (|mul10[NUM_BITS+3:NUM_BITS]) ? {NUM_BITS{1'b1}} : mul10[NUM_BITS-1:0];

  always_comb begin
    num_t  = num_q;
    neg_t  = neg_q;
    stop_t = stop_q;
    if (dc_q == '0 && byte_i == rsp_pkg::CHAR_MINUS) begin
      neg_t = 1'b1;
    end else if (dc_q == '0 && byte_i == rsp_pkg::CHAR_PLUS) begin
      neg_t = neg_q;
    end else if (!stop_q && is_digit) begin
      num_t = num_acc;
    end else begin
      stop_t = 1'b1;
    end
  end

  // range checks
  assign chk_num    = take ? num_t : num_q;
  assign chk_neg    = take ? neg_t : neg_q;
  assign chk_ext    = CMP_W'(chk_num);
  assign cnt_lim    = (CMP_W'(max_count_i) > CNT_LIMIT) ? CNT_LIMIT : CMP_W'(max_count_i);
  assign len_lim    = (CMP_W'(max_length_i) > LEN_LIMIT) ? LEN_LIMIT : CMP_W'(max_length_i);
  assign count_bad  = chk_num == '0 || chk_neg || chk_ext > cnt_lim;
  assign length_bad = (chk_neg && chk_num != '0) || chk_ext > len_lim;
  assign bad        = (phase_q == PH_CNUM) ? count_bad : length_bad;

  assign payload_dec = (payload_q != '0) ? payload_q - 1'b1 : payload_q;
  assign params_dec  = (params_q != '0) ? params_q - 1'b1 : params_q;

  always_comb begin
    phase_d   = phase_q;
    num_d     = num_q;
    neg_d     = neg_q;
    stop_d    = stop_q;
    dc_d      = dc_q;
    params_d  = params_q;
    index_d   = index_q;
    payload_d = payload_q;
    decided_d = decided_q;
    st        = rsp_pkg::ST_PENDING;
    res       = '0;
    if (decided_q != rsp_pkg::ST_PENDING) begin
      st = decided_q;
    end else begin
      case (phase_q)
        PH_STAR, PH_DOLLAR: begin
          if (end_i) begin
            st = rsp_pkg::ST_INCOMPLETE;
          end else if (byte_i != ((phase_q == PH_STAR) ? rsp_pkg::CHAR_STAR
                                                        : rsp_pkg::CHAR_DOLLAR)) begin
            st = rsp_pkg::ST_ERROR;
          end else begin
            num_d   = '0;
            neg_d   = 1'b0;
            stop_d  = 1'b0;
            dc_d    = '0;
            phase_d = (phase_q == PH_STAR) ? PH_CNUM : PH_LNUM;
          end
        end
        PH_CNUM, PH_LNUM: begin
          if (take) begin
            num_d  = num_t;
            neg_d  = neg_t;
            stop_d = stop_t;
            dc_d   = dc_q + 1'b1;
            if (end_i) begin
              st = bad ? rsp_pkg::ST_ERROR : rsp_pkg::ST_INCOMPLETE;
            end
          end else if (bad) begin
            st = rsp_pkg::ST_ERROR;
          end else begin
            if (phase_q == PH_CNUM) begin
              params_d = num_q[COUNT_BITS-1:0];
              index_d  = '0;
            end else begin
              payload_d = num_q[LENGTH_BITS-1:0];
            end
            if (end_i) begin
              st = rsp_pkg::ST_INCOMPLETE;
            end else if (byte_i != rsp_pkg::CHAR_CR) begin
              st = rsp_pkg::ST_ERROR;
            end else begin
              phase_d = (phase_q == PH_CNUM) ? PH_CLF : PH_LLF;
            end
          end
        end
        PH_CLF, PH_LLF: begin
          if (byte_i != rsp_pkg::CHAR_LF) begin
            st = rsp_pkg::ST_ERROR;
          end else begin
            if (phase_q == PH_CLF) begin
              phase_d = PH_DOLLAR;
            end else begin
              phase_d = (payload_q != '0) ? PH_PAYLOAD : PH_DCR;
            end
            if (end_i) begin
              st = rsp_pkg::ST_INCOMPLETE;
            end
          end
        end
        PH_PAYLOAD: begin
          res.data_byte   = byte_i;
          res.data_valid  = 1'b1;
          res.param_index = rsp_pkg::INDEX_W'(index_q);
          payload_d       = payload_dec;
          if (payload_dec == '0) begin
            phase_d = PH_DCR;
          end
          if (end_i) begin
            st = rsp_pkg::ST_INCOMPLETE;
          end
        end
        PH_DCR: begin
          if (end_i) begin
            st = rsp_pkg::ST_INCOMPLETE;
          end else if (byte_i != rsp_pkg::CHAR_CR) begin
            st = rsp_pkg::ST_ERROR;
          end else begin
            phase_d = PH_DLF;
          end
        end
        PH_DLF: begin
          if (byte_i != rsp_pkg::CHAR_LF) begin
            st = rsp_pkg::ST_ERROR;
          end else begin
            res.param_end   = 1'b1;
            res.param_index = rsp_pkg::INDEX_W'(index_q);
            index_d         = index_q + 1'b1;
            params_d        = params_dec;
            if (params_dec == '0) begin
              st = rsp_pkg::ST_OK;
            end else begin
              phase_d = PH_DOLLAR;
              if (end_i) begin
                st = rsp_pkg::ST_INCOMPLETE;
              end
            end
          end
        end
        default: st = rsp_pkg::ST_ERROR;
      endcase
      decided_d = st;
    end
    res.status = st;
    // end of buffer returns the parser to its reset state
    if (end_i) begin
      phase_d   = PH_STAR;
      num_d     = '0;
      neg_d     = 1'b0;
      stop_d    = 1'b0;
      dc_d      = '0;
      params_d  = '0;
      index_d   = '0;
      payload_d = '0;
      decided_d = rsp_pkg::ST_PENDING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_STAR;
      num_q     <= '0;
      neg_q     <= 1'b0;
      stop_q    <= 1'b0;
      dc_q      <= '0;
      params_q  <= '0;
      index_q   <= '0;
      payload_q <= '0;
      decided_q <= rsp_pkg::ST_PENDING;
    end else if (step_i) begin
      phase_q   <= phase_d;
      num_q     <= num_d;
      neg_q     <= neg_d;
      stop_q    <= stop_d;
      dc_q      <= dc_d;
      params_q  <= params_d;
      index_q   <= index_d;
      payload_q <= payload_d;
      decided_q <= decided_d;
    end
  end

  assign res_o = res;

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && end_i |=> phase_q == PH_STAR && decided_q == rsp_pkg::ST_PENDING)
    else $error("parser not back in reset state after end of buffer");

  a_decision_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && !end_i && decided_q != rsp_pkg::ST_PENDING |=> $stable(decided_q))
    else $error("decided status changed before end of buffer");

  a_no_data_after_decision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && decided_q != rsp_pkg::ST_PENDING |-> !res.data_valid && !res.param_end)
    else $error("data delivered after a decision");

  a_data_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res.data_valid |->
      res.status == rsp_pkg::ST_PENDING || res.status == rsp_pkg::ST_INCOMPLETE)
    else $error("payload byte with final status");

  a_data_xor_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> !(res.data_valid && res.param_end))
    else $error("payload byte and end mark together");

endmodule

@@ hw/rtl/rsp_out_stage.sv @@
// result register with valid/stall handshake
module rsp_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  rsp_pkg::res_t res_i,
  input  logic          out_stall_i,
  output logic          free_o,
  output logic          out_valid_o,
  output rsp_pkg::res_t res_o
);

  logic          valid_q, valid_d;
  rsp_pkg::res_t res_q;

  assign free_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule
